@@ src/rgbyuv_pkg.sv @@
`default_nettype none

package rgbyuv_pkg;

  // Default geometry limits
  localparam int MAX_WIDTH_DEF  = 4096;
  localparam int MAX_HEIGHT_DEF = 4096;

  // Register file layout
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  localparam logic [CFG_IDX_W-1:0] REG_SUBSAMPLE_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LINE_WIDTH     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT   = 2'd2;

  // Subsampling modes; the unused code behaves as 4:2:0
  localparam logic [1:0] MODE_444 = 2'd0;
  localparam logic [1:0] MODE_422 = 2'd1;
  localparam logic [1:0] MODE_420 = 2'd2;

  localparam logic [1:0]            MODE_RST   = MODE_444;
  localparam logic [CFG_DATA_W-1:0] WIDTH_RST  = 13'd640;
  localparam logic [CFG_DATA_W-1:0] HEIGHT_RST = 13'd480;

  // 7-bit fixed-point colour matrix
  localparam int FRAC_BITS = 7;

  localparam logic signed [8:0] K_YR = 9'sd33;
  localparam logic signed [8:0] K_YG = 9'sd64;
  localparam logic signed [8:0] K_YB = 9'sd13;
  localparam logic signed [8:0] K_UR = -9'sd19;
  localparam logic signed [8:0] K_UG = -9'sd37;
  localparam logic signed [8:0] K_UB = 9'sd56;
  localparam logic signed [8:0] K_VR = 9'sd56;
  localparam logic signed [8:0] K_VG = -9'sd47;
  localparam logic signed [8:0] K_VB = -9'sd9;

  localparam logic signed [10:0] Y_OFFSET = 11'sd16;
  localparam logic signed [10:0] C_OFFSET = 11'sd128;

  localparam logic [7:0] PIX_MAX = 8'd255;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } pix_t;

  typedef struct packed {
    logic [7:0] luma;
    logic [7:0] chroma_blue;
    logic [7:0] chroma_red;
    logic       chroma_valid;
  } yuv_t;

  // Saturate a small signed value to 0..255
  function automatic logic [7:0] clamp8(input logic signed [10:0] v);
    logic [7:0] res;
    if (v < 11'sd0) begin
      res = 8'd0;
    end else if (v > $signed({3'b000, PIX_MAX})) begin
      res = PIX_MAX;
    end else begin
      res = v[7:0];
    end
    return res;
  endfunction

endpackage

`default_nettype wire

@@ src/rgb_to_yuv_planar_subsampler.sv @@
// Accepted pixels pass the input register, then the result register.
// Throughput: one pixel per clock unless out_ready stalls, set by the
// two-register pipeline (input, result) with a stall-aware ready chain.
// Reset (rst_n low, synchronous): pipeline emptied, column and row counters
// cleared, mode 4:4:4, line width 640, frame height 480.
`default_nettype none

module rgb_to_yuv_planar_subsampler import rgbyuv_pkg::*; #(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // pixel requests
  input  wire logic                  in_valid,
  output      logic                  in_ready,
  input  wire pix_t                  in_data,
  // result requests
  output      logic                  out_valid,
  input  wire logic                  out_ready,
  output      yuv_t                  out_data,
  // register writes
  input  wire logic                  cfg_valid,
  output      logic                  cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int WW = CW + 1;
  localparam int HW = RW + 1;

  // Configuration registers
  logic [1:0]            mode_r;
  logic [CFG_DATA_W-1:0] line_width_r;
  logic [CFG_DATA_W-1:0] frame_height_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r         <= MODE_RST;
      line_width_r   <= WIDTH_RST;
      frame_height_r <= HEIGHT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SUBSAMPLE_MODE: mode_r         <= cfg_data[1:0];
        REG_LINE_WIDTH:     line_width_r   <= cfg_data;
        REG_FRAME_HEIGHT:   frame_height_r <= cfg_data;
        default:            ;
      endcase
    end
  end

  // Effective geometry: zero reads as 1, oversize clips to the maximum
  logic [WW-1:0] w_eff;
  logic [HW-1:0] h_eff;

  always_comb begin
    if (line_width_r == '0) begin
      w_eff = WW'(1);
    end else if (32'(line_width_r) > 32'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(line_width_r);
    end
    if (frame_height_r == '0) begin
      h_eff = HW'(1);
    end else if (32'(frame_height_r) > 32'(MAX_HEIGHT)) begin
      h_eff = HW'(MAX_HEIGHT);
    end else begin
      h_eff = HW'(frame_height_r);
    end
  end

  // Handshake chain
  logic s1_valid_r;
  logic out_valid_r;
  logic out_adv;
  logic s1_adv;
  logic in_acc;

  assign out_adv  = !out_valid_r || out_ready;
  assign s1_adv   = !s1_valid_r || out_adv;
  assign in_ready = s1_adv;
  assign in_acc   = in_valid && in_ready;

  // Raster position counters
  logic [CW-1:0] col_r, col_nxt;
  logic [RW-1:0] row_r, row_nxt;
  logic [WW-1:0] col_inc;
  logic [HW-1:0] row_inc;

  always_comb begin
    col_inc = {1'b0, col_r} + WW'(1);
    row_inc = {1'b0, row_r} + HW'(1);
    col_nxt = col_inc[CW-1:0];
    row_nxt = row_r;
    if (col_inc >= w_eff) begin
      col_nxt = '0;
      row_nxt = (row_inc >= h_eff) ? '0 : row_inc[RW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (in_acc) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // Chroma sample decision for the pixel being accepted
  logic chroma_take;

  always_comb begin
    case (mode_r)
      MODE_444: chroma_take = 1'b1;
      MODE_422: chroma_take = !col_r[0];
      default:  chroma_take = !col_r[0] && !row_r[0];
    endcase
  end

  // Input register
  pix_t s1_pix_r;
  logic s1_chroma_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_adv) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_pix_r    <= in_data;
      s1_chroma_r <= chroma_take;
    end
  end

  // Colour matrix with floor shift, offset and clamp
  logic signed [16:0] rs, gs, bs;
  logic signed [16:0] y_sum, u_sum, v_sum;
  logic signed [16:0] y_sh, u_sh, v_sh;
  logic signed [10:0] y_pre, u_pre, v_pre;
  yuv_t               res;

  always_comb begin
    rs    = $signed({9'b0, s1_pix_r.red});
    gs    = $signed({9'b0, s1_pix_r.green});
    bs    = $signed({9'b0, s1_pix_r.blue});
    y_sum = 17'(K_YR) * rs + 17'(K_YG) * gs + 17'(K_YB) * bs;
    u_sum = 17'(K_UR) * rs + 17'(K_UG) * gs + 17'(K_UB) * bs;
    v_sum = 17'(K_VR) * rs + 17'(K_VG) * gs + 17'(K_VB) * bs;
    y_sh  = y_sum >>> FRAC_BITS;
    u_sh  = u_sum >>> FRAC_BITS;
    v_sh  = v_sum >>> FRAC_BITS;
    y_pre = $signed(y_sh[10:0]) + Y_OFFSET;
    u_pre = $signed(u_sh[10:0]) + C_OFFSET;
    v_pre = $signed(v_sh[10:0]) + C_OFFSET;

    res.luma         = clamp8(y_pre);
    res.chroma_blue  = s1_chroma_r ? clamp8(u_pre) : 8'd0;
    res.chroma_red   = s1_chroma_r ? clamp8(v_pre) : 8'd0;
    res.chroma_valid = s1_chroma_r;
  end

  // Result register
  yuv_t out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_adv && s1_valid_r) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef ASSERT_OFF
  // Luma of any 8-bit pixel lies in 16..239
  a_luma_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r.luma >= 8'd16 && out_data_r.luma <= 8'd239))
    else $error("luma outside nominal range");

  // Chroma fields are zero when no chroma sample is carried
  a_chroma_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_data_r.chroma_valid) |->
      (out_data_r.chroma_blue == 8'd0 && out_data_r.chroma_red == 8'd0))
    else $error("chroma not cleared on luma-only result");

  // Column steps by one or wraps on each accepted pixel
  a_col_step: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (col_r == ($past(col_r) + CW'(1)) || col_r == '0))
    else $error("column counter jumped");

  // Counters hold when no pixel is accepted
  a_cnt_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!in_acc && rst_n) |=> ($stable(col_r) && $stable(row_r)))
    else $error("raster counters moved without a pixel");
`endif

endmodule

`default_nettype wire

@@ tb/yuv_stream_checker.sv @@
module yuv_stream_checker import rgbyuv_pkg::*; #(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  pix_t                  in_data,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  yuv_t                  out_data,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    mismatches,
  output int                    outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  // Local copy of the register file and raster position
  logic [1:0]            chroma_mode;
  logic [CFG_DATA_W-1:0] width_reg;
  logic [CFG_DATA_W-1:0] height_reg;
  int unsigned           col_pos;
  int unsigned           row_pos;

  // Predicted results, oldest first
  yuv_t expected_yuv[$];

  initial begin
    mismatches  = 0;
    outstanding = 0;
  end

  function automatic logic [7:0] sat8(input int v);
    if (v < 0) return 8'd0;
    if (v > 255) return 8'd255;
    return v[7:0];
  endfunction

  // Zero reads as one, oversize reads as the maximum
  function automatic int unsigned bounded(input logic [CFG_DATA_W-1:0] v,
                                          input int unsigned maxv);
    if (v == 0) return 1;
    if (v > maxv) return maxv;
    return v;
  endfunction

  // Integer colour matrix, floor shift by 7, then offset and saturate
  function automatic yuv_t convert_pixel(input pix_t p, input logic chroma_on);
    int   r;
    int   g;
    int   b;
    int   ys;
    int   us;
    int   vs;
    yuv_t res;
    r  = p.red;
    g  = p.green;
    b  = p.blue;
    ys = ((33 * r + 64 * g + 13 * b) >>> 7) + 16;
    us = ((-19 * r - 37 * g + 56 * b) >>> 7) + 128;
    vs = ((56 * r - 47 * g - 9 * b) >>> 7) + 128;
    res.luma         = sat8(ys);
    res.chroma_blue  = chroma_on ? sat8(us) : 8'd0;
    res.chroma_red   = chroma_on ? sat8(vs) : 8'd0;
    res.chroma_valid = chroma_on;
    return res;
  endfunction

  task automatic check_field(input string fname, input int want, input int got);
    if (want != got) begin
      mismatches++;
      $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, fname, want, got);
    end
  endtask

  always @(posedge clk) begin
    yuv_t want;
    logic chroma_on;
    if (!rst_n) begin
      chroma_mode = MODE_RST;
      width_reg   = WIDTH_RST;
      height_reg  = HEIGHT_RST;
      col_pos     = 0;
      row_pos     = 0;
      expected_yuv.delete();
    end else begin
      // Register writes; unknown indexes are dropped
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_SUBSAMPLE_MODE: chroma_mode = cfg_data[1:0];
          REG_LINE_WIDTH:     width_reg   = cfg_data;
          REG_FRAME_HEIGHT:   height_reg  = cfg_data;
          default: ;
        endcase
      end

      // Result requests against the oldest prediction
      if (out_valid && out_ready) begin
        if (expected_yuv.size() == 0) begin
          mismatches++;
          $display("%0t ns: result with nothing expected, expected none, got %h",
                   $time, out_data);
        end else begin
          want = expected_yuv.pop_front();
          check_field("luma", want.luma, out_data.luma);
          check_field("chroma_blue", want.chroma_blue, out_data.chroma_blue);
          check_field("chroma_red", want.chroma_red, out_data.chroma_red);
          check_field("chroma_valid", want.chroma_valid, out_data.chroma_valid);
        end
      end

      // Pixel requests: predict, then step the raster counters
      if (in_valid && in_ready) begin
        case (chroma_mode)
          MODE_444: chroma_on = 1'b1;
          MODE_422: chroma_on = (col_pos % 2 == 0);
          default:  chroma_on = (col_pos % 2 == 0) && (row_pos % 2 == 0);
        endcase
        expected_yuv.push_back(convert_pixel(in_data, chroma_on));
        col_pos++;
        if (col_pos >= bounded(width_reg, MAX_WIDTH)) begin
          col_pos = 0;
          row_pos++;
          if (row_pos >= bounded(height_reg, MAX_HEIGHT)) row_pos = 0;
        end
      end
    end
    outstanding = expected_yuv.size();
  end

endmodule

@@ tb/tb_rgb_to_yuv_planar_subsampler.sv @@
module tb_rgb_to_yuv_planar_subsampler import rgbyuv_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 100;

  // Index outside the register list, and the spare mode code
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam logic [1:0]           MODE_SPARE = 2'd3;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  pix_t                  in_data;
  logic                  out_valid;
  logic                  out_ready;
  yuv_t                  out_data;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int   mismatches;
  int   outstanding;
  int   cycles;
  logic sender_idle;
  logic recv_idle;

  rgb_to_yuv_planar_subsampler DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  yuv_stream_checker yuv_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Run guard
  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("tb_rgb_to_yuv_planar_subsampler: done, errors");
    $finish;
  end

  // Result back-pressure in random bursts
  initial begin
    int hold;
    hold      = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        hold--;
        out_ready <= 1'b0;
      end else if (recv_idle && $urandom_range(0, 6) == 0) begin
        hold = $urandom_range(1, 13) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Called at a falling edge; returns at a falling edge with valid still high unless an idle gap was put in
  task automatic feed(input pix_t p);
    in_valid <= 1'b1;
    in_data  <= p;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    if (sender_idle && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk);
    end
  endtask

  // Stop sending until every predicted result has come back
  task automatic settle();
    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  task automatic set_reg(input logic [CFG_IDX_W-1:0] idx,
                         input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_geometry(input logic [1:0] mode,
                              input logic [CFG_DATA_W-1:0] w,
                              input logic [CFG_DATA_W-1:0] h);
    set_reg(REG_SUBSAMPLE_MODE, CFG_DATA_W'(mode));
    set_reg(REG_LINE_WIDTH, w);
    set_reg(REG_FRAME_HEIGHT, h);
  endtask

  // Mostly tiny sizes, sometimes zero, the maximum, all ones or anything
  function automatic logic [CFG_DATA_W-1:0] pick_dim();
    case ($urandom_range(0, 19))
      0:       return '0;
      1:       return CFG_DATA_W'(MAX_WIDTH_DEF);
      2:       return '1;
      3:       return CFG_DATA_W'($urandom);
      default: return CFG_DATA_W'($urandom_range(1, 9));
    endcase
  endfunction

  function automatic logic [7:0] pick_level();
    if ($urandom_range(0, 7) == 0) return ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
    return 8'($urandom);
  endfunction

  function automatic pix_t random_pixel();
    pix_t p;
    p.blue  = pick_level();
    p.green = pick_level();
    p.red   = pick_level();
    return p;
  endfunction

  initial begin
    pix_t corners[8];
    corners[0] = '{blue: 8'd0,   green: 8'd0,   red: 8'd0};
    corners[1] = '{blue: 8'd255, green: 8'd255, red: 8'd255};
    corners[2] = '{blue: 8'd0,   green: 8'd0,   red: 8'd255};
    corners[3] = '{blue: 8'd0,   green: 8'd255, red: 8'd0};
    corners[4] = '{blue: 8'd255, green: 8'd0,   red: 8'd0};
    corners[5] = '{blue: 8'd0,   green: 8'd255, red: 8'd255};
    corners[6] = '{blue: 8'd255, green: 8'd255, red: 8'd0};
    // a small negative blue-difference sum exercises the floor rounding
    corners[7] = '{blue: 8'd0,   green: 8'd1,   red: 8'd1};

    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_data     = '0;
    cfg_valid   = 1'b0;
    cfg_index   = '0;
    cfg_data    = '0;
    sender_idle = 1'b1;
    recv_idle   = 1'b1;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    // Colour corners at the reset geometry
    foreach (corners[i]) feed(corners[i]);

    // Odd width in 4:2:2, two rows
    settle();
    set_geometry(MODE_422, 13'd3, 13'd2);
    repeat (6) feed(random_pixel());

    // Spare mode acts as 4:2:0, zero width reads as one; stray index ignored
    settle();
    set_geometry(MODE_SPARE, 13'd0, 13'd2);
    set_reg(REG_UNUSED, CFG_DATA_W'(MODE_444));
    repeat (4) feed(random_pixel());

    // Oversize width, zero height
    settle();
    set_geometry(MODE_420, '1, 13'd0);
    repeat (3) feed(random_pixel());

    // Largest legal geometry
    settle();
    set_geometry(MODE_422, 13'd4096, 13'd4096);
    repeat (2) feed(random_pixel());

    // Random phases; counters carry across geometry changes
    for (int ph = 0; ph < PHASES; ph++) begin
      settle();
      if (ph == PHASES - 1) begin
        sender_idle = 1'b0;
        recv_idle   = 1'b0;
      end else begin
        sender_idle = ($urandom_range(0, 3) != 0);
        recv_idle   = ($urandom_range(0, 3) != 0);
      end
      set_reg(REG_SUBSAMPLE_MODE, CFG_DATA_W'($urandom_range(0, 3)));
      if ($urandom_range(0, 2) != 0) set_reg(REG_LINE_WIDTH, pick_dim());
      if ($urandom_range(0, 2) != 0) set_reg(REG_FRAME_HEIGHT, pick_dim());
      if ($urandom_range(0, 3) == 0) set_reg(REG_UNUSED, CFG_DATA_W'($urandom));
      repeat (PHASE_ITEMS) feed(random_pixel());
    end

    // Drain and let any stray result show up
    settle();
    repeat (8) @(negedge clk);
    if (mismatches == 0) begin
      $display("tb_rgb_to_yuv_planar_subsampler: done, clean");
    end else begin
      $display("tb_rgb_to_yuv_planar_subsampler: done, errors");
    end
    $finish;
  end

endmodule

@@ files.f @@
src/rgbyuv_pkg.sv
src/rgb_to_yuv_planar_subsampler.sv
tb/yuv_stream_checker.sv
tb/tb_rgb_to_yuv_planar_subsampler.sv
